### design/gis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grayscale image scaler package
// Shared sizes, command types and helper functions of the scaler.
// ----------------------------------------------------------------------------
package gis_pkg;

    localparam int MAX_IN_WIDTH  = 512;
    localparam int MAX_IN_HEIGHT = 512;
    localparam int MAX_OUT_SIZE  = 4096;

    localparam int IW_W   = 10;
    localparam int OW_W   = 13;
    localparam int LC_W   = 9;
    localparam int OC_W   = 12;
    localparam int PIX_W  = 8;
    localparam int FRAC_W = 16;

    localparam int STORE_DEPTH = MAX_IN_WIDTH * MAX_IN_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(MAX_IN_WIDTH) + FRAC_W;
    localparam int XS_W        = OC_W + IW_W;
    localparam int SUM_W       = PIX_W + ADDR_W;
    localparam int DVD_W       = SUM_W;
    localparam int DVS_W       = ADDR_W + 1;
    localparam int DIV_CNT_W   = $clog2(DVD_W + 1);
    localparam int MID_W       = PIX_W + FRAC_W + 2;
    localparam int V_W         = MID_W + FRAC_W + 2;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLICATE  = 3'd4;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_SKIP,
        OP_FIXED,
        OP_ENLARGE,
        OP_AREA
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  wdata;
        logic [OC_W-1:0]   col;
        logic [OC_W-1:0]   row;
        logic [IW_W-1:0]   ix;
        logic [IW_W-1:0]   iy;
        logic [OW_W-1:0]   ox;
        logic [OW_W-1:0]   oy;
        logic              repl;
        logic              status;
        logic [XS_W-1:0]   xs;
        logic [XS_W-1:0]   ys;
    } cmd_t;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IW_W-1:0] c,
                                                   input logic [IW_W-1:0] r);
        logic [ADDR_W+IW_W-1:0] t;
        t = (ADDR_W+IW_W)'(r) * (ADDR_W+IW_W)'(MAX_IN_WIDTH) + (ADDR_W+IW_W)'(c);
        return t[ADDR_W-1:0];
    endfunction

    function automatic logic [IW_W-1:0] clamp_in(input logic [IW_W-1:0] v,
                                                 input logic [IW_W-1:0] hi);
        logic [IW_W-1:0] r;
        r = v;
        if (v == '0) r = IW_W'(1);
        if (v > hi) r = hi;
        return r;
    endfunction

    function automatic logic [OW_W-1:0] clamp_out(input logic [OW_W-1:0] v);
        logic [OW_W-1:0] r;
        r = v;
        if (v == '0) r = OW_W'(1);
        if (v > OW_W'(MAX_OUT_SIZE)) r = OW_W'(MAX_OUT_SIZE);
        return r;
    endfunction

endpackage

### design/gis_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grayscale image scaler channels
// Request, result and configuration write channels with valid and ready.
// ----------------------------------------------------------------------------
interface gis_req_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [gis_pkg::LC_W-1:0]  load_col;
    logic [gis_pkg::LC_W-1:0]  load_row;
    logic [gis_pkg::PIX_W-1:0] load_value;
    logic [gis_pkg::OC_W-1:0]  out_col;
    logic [gis_pkg::OC_W-1:0]  out_row;
    modport source (output valid, mode, load_col, load_row, load_value, out_col, out_row,
                    input ready);
    modport sink (input valid, mode, load_col, load_row, load_value, out_col, out_row,
                  output ready);
endinterface

interface gis_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [gis_pkg::PIX_W-1:0] pixel_out;
    logic                      status;
    modport source (output valid, pixel_out, status, input ready);
    modport sink (input valid, pixel_out, status, output ready);
endinterface

interface gis_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gis_pkg::CFG_IDX_W-1:0]  index;
    logic [gis_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### design/gis_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaler front end
// Holds the configuration registers and turns each request into a command.
// ----------------------------------------------------------------------------
module gis_front (
    input  logic          clk,
    input  logic          rst_n,
    gis_req_if.sink       req,
    gis_cfg_if.sink       cfg,
    output gis_pkg::cmd_t push_cmd,
    output logic          push,
    input  logic          q_full
);
    import gis_pkg::*;

    logic [IW_W-1:0] in_width_reg;
    logic [IW_W-1:0] in_height_reg;
    logic [OW_W-1:0] out_width_reg;
    logic [OW_W-1:0] out_height_reg;
    logic            replicate_reg;

    logic [IW_W-1:0] ix;
    logic [IW_W-1:0] iy;
    logic [OW_W-1:0] ox;
    logic [OW_W-1:0] oy;
    logic            mixed;
    logic            outside;

    assign cfg.ready = 1'b1;
    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg   <= IW_W'(512);
            in_height_reg  <= IW_W'(512);
            out_width_reg  <= OW_W'(512);
            out_height_reg <= OW_W'(512);
            replicate_reg  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_IN_WIDTH:   in_width_reg   <= cfg.data[IW_W-1:0];
                CFG_IN_HEIGHT:  in_height_reg  <= cfg.data[IW_W-1:0];
                CFG_OUT_WIDTH:  out_width_reg  <= cfg.data[OW_W-1:0];
                CFG_OUT_HEIGHT: out_height_reg <= cfg.data[OW_W-1:0];
                CFG_REPLICATE:  replicate_reg  <= cfg.data[0];
                default:        ;
            endcase
        end
    end

    assign ix = clamp_in(in_width_reg, IW_W'(MAX_IN_WIDTH));
    assign iy = clamp_in(in_height_reg, IW_W'(MAX_IN_HEIGHT));
    assign ox = clamp_out(out_width_reg);
    assign oy = clamp_out(out_height_reg);

    assign mixed = ((OW_W'(ix) < ox) && (OW_W'(iy) > oy)) ||
                   ((OW_W'(ix) > ox) && (OW_W'(iy) < oy));
    assign outside = (OW_W'(req.out_col) >= ox) || (OW_W'(req.out_row) >= oy);

    always_comb
    begin
        push_cmd        = '0;
        push_cmd.addr   = addr_of(IW_W'(req.load_col), IW_W'(req.load_row));
        push_cmd.wdata  = req.load_value;
        push_cmd.col    = req.out_col;
        push_cmd.row    = req.out_row;
        push_cmd.ix     = ix;
        push_cmd.iy     = iy;
        push_cmd.ox     = ox;
        push_cmd.oy     = oy;
        push_cmd.repl   = replicate_reg;
        push_cmd.xs     = req.out_col * ix;
        push_cmd.ys     = req.out_row * iy;
        if (!req.mode)
        begin
            if ((IW_W'(req.load_col) < IW_W'(MAX_IN_WIDTH)) &&
                (IW_W'(req.load_row) < IW_W'(MAX_IN_HEIGHT)))
                push_cmd.op = OP_WRITE;
            else
                push_cmd.op = OP_SKIP;
        end
        else if (mixed)
        begin
            push_cmd.op     = OP_FIXED;
            push_cmd.status = 1'b1;
        end
        else if (outside)
            push_cmd.op = OP_FIXED;
        else if ((OW_W'(ix) < ox) || (OW_W'(iy) < oy))
            push_cmd.op = OP_ENLARGE;
        else
            push_cmd.op = OP_AREA;
    end

endmodule

### design/gis_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaler command queue
// Short queue of commands between the front end and the execution unit.
// ----------------------------------------------------------------------------
module gis_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gis_pkg::cmd_t push_cmd,
    input  logic          pop,
    output gis_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);
    import gis_pkg::*;

    cmd_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### design/gis_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaler divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gis_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [gis_pkg::DVD_W-1:0] dividend,
    input  logic [gis_pkg::DVS_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [gis_pkg::DVD_W-1:0] quotient,
    output logic [gis_pkg::DVS_W-1:0] remainder
);
    import gis_pkg::*;

    logic [DVD_W-1:0]     quo_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DVS_W:0]       trial;
    logic                 fits;

    assign trial     = {rem_reg, quo_reg[DVD_W-1]};
    assign fits      = (trial >= {1'b0, dvs_reg});
    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= DIV_CNT_W'(DVD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### design/gis_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaler execution unit
// Owns the frame store and computes area averages and enlarged samples.
// ----------------------------------------------------------------------------
module gis_back (
    input  logic          clk,
    input  logic          rst_n,
    input  gis_pkg::cmd_t q_head,
    input  logic          q_empty,
    output logic          q_pop,
    gis_rsp_if.source     rsp
);
    import gis_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_EN_DX, S_EN_DY, S_EN_POS, S_EN_RD, S_EN_CAP, S_EN_MID, S_EN_V,
        S_EN_FIN, S_AR_K0, S_AR_K1, S_AR_L0, S_AR_L1, S_AR_PIX, S_AR_MUL, S_AR_ACC,
        S_AR_DIV, S_EMIT
    } state_t;

    state_t state_reg;
    cmd_t   cmd_reg;

    logic [PIX_W-1:0]  frame_mem [STORE_DEPTH];
    logic [PIX_W-1:0]  rdata_reg;
    logic [ADDR_W-1:0] raddr;
    logic              mem_we;

    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic             div_busy;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;
    logic [DVS_W-1:0] div_rem;

    logic [POS_W-1:0]        xstep_reg;
    logic [POS_W-1:0]        ystep_reg;
    logic [POS_W-1:0]        xp_reg;
    logic [POS_W-1:0]        yp_reg;
    logic [1:0]              nb_reg;
    logic [PIX_W-1:0]        p_reg [4];
    logic signed [MID_W-1:0] m1_reg;
    logic signed [MID_W-1:0] m2_reg;
    logic signed [V_W-1:0]   v_reg;

    logic [IW_W-1:0]    k0_reg, k1_reg, k_reg, l_reg, l1_reg;
    logic [XS_W-1:0]    c0_reg, c_reg, a_reg;
    logic [2*OW_W-1:0]  wxy_reg;
    logic [SUM_W-1:0]   prod_reg;
    logic [SUM_W-1:0]   sum_reg;

    logic [PIX_W-1:0] pix_reg;
    logic             st_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_st_reg;

    logic [POS_W-FRAC_W-1:0] x0, y0;
    logic [FRAC_W-1:0]       dx, dy;
    logic                    nb_need;
    logic [XS_W-1:0]         xe, ye, c_end, a_end, x_hi, x_lo, y_hi, y_lo;
    logic [OW_W-1:0]         wx, wy;
    logic [2*IW_W-1:0]       area;

    logic signed [PIX_W:0]    d01, d23;
    logic signed [FRAC_W:0]   dx_s, dy_s;
    logic signed [MID_W-1:0]  t1, t2, m1_c, m2_c;
    logic signed [MID_W:0]    dm;
    logic signed [V_W-1:0]    t3, v_c;
    logic [PIX_W-1:0]         v_pix;

    gis_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign x0 = xp_reg[POS_W-1:FRAC_W];
    assign y0 = yp_reg[POS_W-1:FRAC_W];
    assign dx = xp_reg[FRAC_W-1:0];
    assign dy = yp_reg[FRAC_W-1:0];

    assign xe    = cmd_reg.xs + XS_W'(cmd_reg.ix);
    assign ye    = cmd_reg.ys + XS_W'(cmd_reg.iy);
    assign c_end = c_reg + XS_W'(cmd_reg.ox);
    assign a_end = a_reg + XS_W'(cmd_reg.oy);
    assign x_hi  = (c_end < xe) ? c_end : xe;
    assign x_lo  = (c_reg > cmd_reg.xs) ? c_reg : cmd_reg.xs;
    assign y_hi  = (a_end < ye) ? a_end : ye;
    assign y_lo  = (a_reg > cmd_reg.ys) ? a_reg : cmd_reg.ys;
    assign wx    = OW_W'(x_hi - x_lo);
    assign wy    = OW_W'(y_hi - y_lo);
    assign area  = cmd_reg.ix * cmd_reg.iy;

    always_comb
    begin
        case (nb_reg)
            2'd0:    nb_need = 1'b1;
            2'd1:    nb_need = (dx != '0);
            2'd2:    nb_need = (dy != '0);
            default: nb_need = (dx != '0) && (dy != '0);
        endcase
    end

    always_comb
    begin
        d01  = $signed({1'b0, p_reg[1]}) - $signed({1'b0, p_reg[0]});
        d23  = $signed({1'b0, p_reg[3]}) - $signed({1'b0, p_reg[2]});
        dx_s = $signed({1'b0, dx});
        dy_s = $signed({1'b0, dy});
        t1   = dx_s * d01;
        t2   = dx_s * d23;
        m1_c = $signed({2'b00, p_reg[0], {FRAC_W{1'b0}}}) + t1;
        m2_c = $signed({2'b00, p_reg[2], {FRAC_W{1'b0}}}) + t2;
        dm   = m2_reg - m1_reg;
        t3   = dy_s * dm;
        v_c  = $signed({m1_reg, {FRAC_W{1'b0}}}) + t3;
        if (v_reg < 0)
            v_pix = '0;
        else if (v_reg[V_W-1:2*FRAC_W] > (V_W-2*FRAC_W)'(255))
            v_pix = PIX_W'(255);
        else
            v_pix = v_reg[2*FRAC_W+PIX_W-1:2*FRAC_W];
    end

    always_comb
    begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        raddr     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop  = 1'b1;
                    mem_we = (q_head.op == OP_WRITE);
                    if (q_head.op == OP_ENLARGE)
                    begin
                        div_start = 1'b1;
                        div_dvd   = DVD_W'({q_head.ix - IW_W'(1), {FRAC_W{1'b0}}});
                        div_dvs   = DVS_W'(q_head.ox);
                    end
                    else if (q_head.op == OP_AREA)
                    begin
                        div_start = 1'b1;
                        div_dvd   = DVD_W'(q_head.xs);
                        div_dvs   = DVS_W'(q_head.ox);
                    end
                end
            end
            S_EN_DX:
            begin
                div_start = div_done;
                div_dvd   = DVD_W'({cmd_reg.iy - IW_W'(1), {FRAC_W{1'b0}}});
                div_dvs   = DVS_W'(cmd_reg.oy);
            end
            S_EN_RD:
                raddr = addr_of(IW_W'(x0) + IW_W'(nb_reg[0]), IW_W'(y0) + IW_W'(nb_reg[1]));
            S_AR_K0:
            begin
                div_start = div_done;
                div_dvd   = DVD_W'(xe) + DVD_W'(cmd_reg.ox) - DVD_W'(1);
                div_dvs   = DVS_W'(cmd_reg.ox);
            end
            S_AR_K1:
            begin
                div_start = div_done;
                div_dvd   = DVD_W'(cmd_reg.ys);
                div_dvs   = DVS_W'(cmd_reg.oy);
            end
            S_AR_L0:
            begin
                div_start = div_done;
                div_dvd   = DVD_W'(ye) + DVD_W'(cmd_reg.oy) - DVD_W'(1);
                div_dvs   = DVS_W'(cmd_reg.oy);
            end
            S_AR_PIX:
            begin
                raddr     = addr_of(k_reg, l_reg);
                div_start = (l_reg >= l1_reg);
                div_dvd   = sum_reg;
                div_dvs   = DVS_W'(area);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[q_head.addr] <= q_head.wdata;
        rdata_reg <= frame_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            xstep_reg     <= '0;
            ystep_reg     <= '0;
            xp_reg        <= '0;
            yp_reg        <= '0;
            nb_reg        <= '0;
            p_reg         <= '{default: '0};
            m1_reg        <= '0;
            m2_reg        <= '0;
            v_reg         <= '0;
            k0_reg        <= '0;
            k1_reg        <= '0;
            k_reg         <= '0;
            l_reg         <= '0;
            l1_reg        <= '0;
            c0_reg        <= '0;
            c_reg         <= '0;
            a_reg         <= '0;
            wxy_reg       <= '0;
            prod_reg      <= '0;
            sum_reg       <= '0;
            pix_reg       <= '0;
            st_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_pix_reg   <= '0;
            out_st_reg    <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_EMIT) && (!out_valid_reg || rsp.ready))
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg <= q_head;
                        case (q_head.op)
                            OP_FIXED:
                            begin
                                pix_reg   <= '0;
                                st_reg    <= q_head.status;
                                state_reg <= S_EMIT;
                            end
                            OP_ENLARGE: state_reg <= S_EN_DX;
                            OP_AREA:    state_reg <= S_AR_K0;
                            default:    ;
                        endcase
                    end
                end
                S_EN_DX:
                begin
                    if (div_done)
                    begin
                        xstep_reg <= div_quo[POS_W-1:0];
                        state_reg <= S_EN_DY;
                    end
                end
                S_EN_DY:
                begin
                    if (div_done)
                    begin
                        ystep_reg <= div_quo[POS_W-1:0];
                        state_reg <= S_EN_POS;
                    end
                end
                S_EN_POS:
                begin
                    xp_reg    <= POS_W'(cmd_reg.col * xstep_reg);
                    yp_reg    <= POS_W'(cmd_reg.row * ystep_reg);
                    nb_reg    <= '0;
                    state_reg <= S_EN_RD;
                end
                S_EN_RD:
                    state_reg <= S_EN_CAP;
                S_EN_CAP:
                begin
                    p_reg[nb_reg] <= nb_need ? rdata_reg : '0;
                    if (cmd_reg.repl)
                    begin
                        pix_reg   <= rdata_reg;
                        st_reg    <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                    else if (nb_reg == 2'd3)
                        state_reg <= S_EN_MID;
                    else
                    begin
                        nb_reg    <= nb_reg + 2'd1;
                        state_reg <= S_EN_RD;
                    end
                end
                S_EN_MID:
                begin
                    m1_reg    <= m1_c;
                    m2_reg    <= m2_c;
                    state_reg <= S_EN_V;
                end
                S_EN_V:
                begin
                    v_reg     <= v_c;
                    state_reg <= S_EN_FIN;
                end
                S_EN_FIN:
                begin
                    pix_reg   <= v_pix;
                    st_reg    <= 1'b0;
                    state_reg <= S_EMIT;
                end
                S_AR_K0:
                begin
                    if (div_done)
                    begin
                        k0_reg    <= div_quo[IW_W-1:0];
                        k_reg     <= div_quo[IW_W-1:0];
                        c0_reg    <= cmd_reg.xs - XS_W'(div_rem);
                        c_reg     <= cmd_reg.xs - XS_W'(div_rem);
                        state_reg <= S_AR_K1;
                    end
                end
                S_AR_K1:
                begin
                    if (div_done)
                    begin
                        k1_reg    <= (div_quo > DVD_W'(cmd_reg.ix)) ? cmd_reg.ix
                                                                    : div_quo[IW_W-1:0];
                        state_reg <= S_AR_L0;
                    end
                end
                S_AR_L0:
                begin
                    if (div_done)
                    begin
                        l_reg     <= div_quo[IW_W-1:0];
                        a_reg     <= cmd_reg.ys - XS_W'(div_rem);
                        state_reg <= S_AR_L1;
                    end
                end
                S_AR_L1:
                begin
                    if (div_done)
                    begin
                        l1_reg    <= (div_quo > DVD_W'(cmd_reg.iy)) ? cmd_reg.iy
                                                                    : div_quo[IW_W-1:0];
                        sum_reg   <= '0;
                        state_reg <= S_AR_PIX;
                    end
                end
                S_AR_PIX:
                begin
                    if (l_reg >= l1_reg)
                        state_reg <= S_AR_DIV;
                    else
                    begin
                        wxy_reg   <= wx * wy;
                        state_reg <= S_AR_MUL;
                    end
                end
                S_AR_MUL:
                begin
                    prod_reg <= SUM_W'(rdata_reg * wxy_reg);
                    if ((k_reg + IW_W'(1)) < k1_reg)
                    begin
                        k_reg <= k_reg + IW_W'(1);
                        c_reg <= c_end;
                    end
                    else
                    begin
                        k_reg <= k0_reg;
                        c_reg <= c0_reg;
                        l_reg <= l_reg + IW_W'(1);
                        a_reg <= a_end;
                    end
                    state_reg <= S_AR_ACC;
                end
                S_AR_ACC:
                begin
                    sum_reg   <= sum_reg + prod_reg;
                    state_reg <= S_AR_PIX;
                end
                S_AR_DIV:
                begin
                    if (div_done)
                    begin
                        pix_reg   <= div_quo[PIX_W-1:0];
                        st_reg    <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_pix_reg   <= pix_reg;
                        out_st_reg    <= st_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.pixel_out = out_pix_reg;
    assign rsp.status    = out_st_reg;

    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE))
        else $error("command taken while a command is in progress");

    a_col_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_AR_PIX) && (l_reg < l1_reg)) |-> (k_reg < k1_reg))
        else $error("footprint column beyond its span");

    a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && !out_valid_reg) |=> out_valid_reg)
        else $error("finished result not presented");

endmodule

### design/grayscale_image_scaler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grayscale image scaler
// Stores an 8-bit frame and returns pixels of a scaled copy of it.
// ----------------------------------------------------------------------------
// The req channel carries one transaction per request. A write request (mode
// 0) stores one pixel and gives no result. A compute request (mode 1) gives
// one transaction on rsp with the scaled pixel and a status bit that flags
// enlarging one axis while shrinking the other. Sizes and the replication
// mode are written over cfg, one register per transaction; the user must do
// so only while idle, which the block does not enforce. Requests wait in a
// two-entry queue; a write is stored as it leaves the queue. A refused
// compute request or one outside the output image gives a zero pixel. An
// enlarged sample takes two divisions for the steps, then reads the four
// neighbours and interpolates; nearest sampling ends after its first read.
// An area average takes four divisions for the footprint bounds, a read,
// multiply and accumulate per input pixel under it, and a final division.
// Reset clears the control state and the registers to their defaults; the
// frame store holds no defined value until a pixel is written. A result
// waits in the output register while rsp stalls; the next request is
// worked on in the meantime and waits only to present its own result.
// ----------------------------------------------------------------------------
module grayscale_image_scaler_unit (
    input  logic      clk,
    input  logic      rst_n,
    gis_req_if.sink   req,
    gis_rsp_if.source rsp,
    gis_cfg_if.sink   cfg
);
    import gis_pkg::*;

    cmd_t push_cmd;
    cmd_t q_head;
    logic push;
    logic q_pop;
    logic q_empty;
    logic q_full;

    gis_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg      (cfg),
        .push_cmd (push_cmd),
        .push     (push),
        .q_full   (q_full)
    );

    gis_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    gis_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grayscale image scaler testbench
// Loads small frames, sets sizes over the register channel and checks every
// scaled pixel against a predictor of area averaging, bilinear and nearest
// sampling, under random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
    import gis_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             status;
    } scaled_t;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    logic running;
    int   cycles;
    int   burst_left;

    gis_req_if req ();
    gis_rsp_if rsp ();
    gis_cfg_if cfg ();

    grayscale_image_scaler_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    logic [PIX_W-1:0] frame_model [int];
    int               img_w, img_h, scl_w, scl_h;
    logic             nearest;
    scaled_t          pending_pixels [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    function automatic longint pix_at(input longint c, input longint r);
        if (c >= MAX_IN_WIDTH || r >= MAX_IN_HEIGHT) return 0;
        if (!frame_model.exists(int'(r * MAX_IN_WIDTH + c))) return 0;
        return frame_model[int'(r * MAX_IN_WIDTH + c)];
    endfunction

    function automatic longint sat(input longint v, input longint hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic scaled_t scale_pixel(input longint i, input longint j);
        scaled_t res;
        longint  ix, iy, ox, oy;
        longint  xs, xe, ys, ye, k0, k1, l0, l1, sum, wx, wy, a, b, c, d;
        longint  xstep, ystep, xp, yp, x0, y0, dx, dy, p00, p01, p10, p11, m1, m2, v;
        ix = sat(img_w, MAX_IN_WIDTH);
        iy = sat(img_h, MAX_IN_HEIGHT);
        ox = sat(scl_w, MAX_OUT_SIZE);
        oy = sat(scl_h, MAX_OUT_SIZE);
        res.pixel = '0;
        res.status = 1'b0;
        if ((ix < ox && iy > oy) || (ix > ox && iy < oy))
            res.status = 1'b1;
        else if (i >= ox || j >= oy)
            res.pixel = '0;
        else if (ix < ox || iy < oy)
        begin
            xstep = ((ix - 1) << 16) / ox;
            ystep = ((iy - 1) << 16) / oy;
            xp = i * xstep;
            yp = j * ystep;
            x0 = xp >> 16;
            y0 = yp >> 16;
            dx = xp & 16'hFFFF;
            dy = yp & 16'hFFFF;
            p00 = pix_at(x0, y0);
            p01 = 0;
            p10 = 0;
            p11 = 0;
            if (nearest)
                res.pixel = p00[7:0];
            else
            begin
                if (dx != 0) p01 = pix_at(x0 + 1, y0);
                if (dy != 0)
                begin
                    p10 = pix_at(x0, y0 + 1);
                    if (dx != 0) p11 = pix_at(x0 + 1, y0 + 1);
                end
                m1 = p00 * 65536 + dx * (p01 - p00);
                m2 = p10 * 65536 + dx * (p11 - p10);
                v = m1 * 65536 + dy * (m2 - m1);
                if (v < 0) v = 0;
                v = v >>> 32;
                if (v > 255) v = 255;
                res.pixel = v[7:0];
            end
        end
        else
        begin
            xs = i * ix;
            xe = xs + ix;
            ys = j * iy;
            ye = ys + iy;
            k0 = xs / ox;
            k1 = (xe + ox - 1) / ox;
            l0 = ys / oy;
            l1 = (ye + oy - 1) / oy;
            if (k1 > ix) k1 = ix;
            if (l1 > iy) l1 = iy;
            sum = 0;
            for (longint l = l0; l < l1; l++)
            begin
                a = l * oy;
                b = a + oy;
                wy = ((b < ye) ? b : ye) - ((a > ys) ? a : ys);
                for (longint k = k0; k < k1; k++)
                begin
                    c = k * ox;
                    d = c + ox;
                    wx = ((d < xe) ? d : xe) - ((c > xs) ? c : xs);
                    sum += pix_at(k, l) * wx * wy;
                end
            end
            sum = sum / (ix * iy);
            res.pixel = sum[7:0];
        end
        return res;
    endfunction

    // Result checker with its own stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        scaled_t want;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_pixels.size() == 0)
                    report_mismatch("unexpected transaction", 1, 0);
                else
                begin
                    want = pending_pixels.pop_front();
                    if (rsp.pixel_out !== want.pixel)
                        report_mismatch("pixel_out", rsp.pixel_out, want.pixel);
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                end
            end
            if ((cycles % 512) < 128)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_item(input logic m, input int lc, input int lr, input int lv,
                             input int oc, input int orow);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        burst_left--;
        req.valid      <= 1'b1;
        req.mode       <= m;
        req.load_col   <= lc[LC_W-1:0];
        req.load_row   <= lr[LC_W-1:0];
        req.load_value <= lv[PIX_W-1:0];
        req.out_col    <= oc[OC_W-1:0];
        req.out_row    <= orow[OC_W-1:0];
        do @(posedge clk); while (!req.ready);
        if (m == 1'b0)
        begin
            if (lc < MAX_IN_WIDTH && lr < MAX_IN_HEIGHT)
                frame_model[lr * MAX_IN_WIDTH + lc] = lv[PIX_W-1:0];
        end
        else
            pending_pixels.push_back(scale_pixel(oc, orow));
        if (burst_left == 0)
            req.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        if (burst_left != 0)
        begin
            req.valid <= 1'b0;
            burst_left = 0;
        end
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            CFG_IN_WIDTH:   img_w = value & 10'h3FF;
            CFG_IN_HEIGHT:  img_h = value & 10'h3FF;
            CFG_OUT_WIDTH:  scl_w = value & 13'h1FFF;
            CFG_OUT_HEIGHT: scl_h = value & 13'h1FFF;
            CFG_REPLICATE:  nearest = value[0];
            default: ;
        endcase
    endtask

    task automatic set_sizes(input int iw, input int ih, input int ow, input int oh,
                             input logic repl);
        wait_idle();
        write_reg(CFG_IN_WIDTH, iw);
        write_reg(CFG_IN_HEIGHT, ih);
        write_reg(CFG_OUT_WIDTH, ow);
        write_reg(CFG_OUT_HEIGHT, oh);
        write_reg(CFG_REPLICATE, repl);
        cfg.valid <= 1'b0;
    endtask

    task automatic load_frame(input int w, input int h, input int kind);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                send_item(1'b0, c, r,
                          (kind == 0) ? 255 : (kind == 1) ? 0 : $urandom_range(0, 255),
                          $urandom, $urandom);
    endtask

    task automatic request_pixel(input int oc, input int orow);
        send_item(1'b1, $urandom, $urandom, $urandom, oc, orow);
    endtask

    task automatic test_directed();
        load_frame(4, 4, 0);
        set_sizes(4, 4, 2, 2, 1'b0);
        request_pixel(0, 0);
        request_pixel(1, 1);
        request_pixel(2, 0);
        request_pixel(4095, 4095);
        set_sizes(4, 4, 8, 2, 1'b0);
        request_pixel(0, 0);
        set_sizes(4, 4, 4095, 4096, 1'b0);
        request_pixel(4094, 4095);
        request_pixel(0, 0);
        set_sizes(0, 0, 0, 0, 1'b1);
        request_pixel(0, 0);
        request_pixel(1, 0);
        send_item(1'b0, 0, 0, 0, 0, 0);
        send_item(1'b0, 511, 511, 128, 0, 0);
        send_item(1'b0, 511, 0, 77, 0, 0);
        request_pixel(0, 0);
    endtask

    task automatic test_large_frame();
        for (int r = 0; r < 2; r++)
            for (int c = 508; c < 512; c++)
            begin
                send_item(1'b0, c, r, $urandom_range(0, 255), 0, 0);
                send_item(1'b0, c, 511 - r, $urandom_range(0, 255), 0, 0);
            end
        set_sizes(512, 512, 8191, 8191, 1'b1);
        request_pixel(4095, 4095);
        request_pixel(4095, 0);
        set_sizes(1023, 1023, 4096, 4096, 1'b0);
        request_pixel(4095, 4095);
        request_pixel(4095, 0);
    endtask

    task automatic test_random_scaling();
        int iw, ih, ow, oh, kind;
        for (int p = 0; p < 36; p++)
        begin
            iw = $urandom_range(1, 6);
            ih = $urandom_range(1, 6);
            kind = $urandom_range(0, 3);
            ow = (kind == 0) ? $urandom_range(1, iw) : $urandom_range(iw, 40);
            oh = (kind == 0) ? $urandom_range(1, ih) : $urandom_range(ih, 40);
            if (kind == 3)
                oh = $urandom_range(1, 40);
            set_sizes(iw, ih, ow, oh, $urandom_range(0, 1));
            load_frame(iw, ih, 2);
            for (int n = 0; n < 25; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    request_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
                else
                    request_pixel($urandom_range(0, ow), $urandom_range(0, oh));
            end
            if (p == 10)
                wait_idle();
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        cycles = 0;
        burst_left = 0;
        img_w = 512;
        img_h = 512;
        scl_w = 512;
        scl_h = 512;
        nearest = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.mode = 1'b0;
        req.load_col = '0;
        req.load_row = '0;
        req.load_value = '0;
        req.out_col = '0;
        req.out_row = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_large_frame();
        test_random_scaling();
        wait_idle();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
design/gis_pkg.sv
design/gis_ifs.sv
design/gis_front.sv
design/gis_cmd_fifo.sv
design/gis_div.sv
design/gis_back.sv
design/grayscale_image_scaler_unit.sv
tb/tb.sv
